FILE: design/fpdvc_pkg.sv
`default_nettype none

package fpdvc_pkg;

    // data widths
    localparam int NUM_AXES  = 4;
    localparam int VEL_W     = 16;
    localparam int ERR_W     = VEL_W + 1;
    localparam int DE_W      = ERR_W + 1;
    localparam int GAIN_W    = 15;
    localparam int TIME_W    = 32;
    localparam int FRAC_BITS = 12;

    // derivative numerator: kd * de * 1e6, with 1e6 = 15625 << 6
    localparam int SCALE_W     = 14;
    localparam int SCALE_SHIFT = 6;
    localparam logic [SCALE_W-1:0] D_SCALE = 14'd15625;

    localparam int PD_W    = GAIN_W + 1 + DE_W;
    localparam int PDMAG_W = PD_W - 1;
    localparam int MAG_W   = PDMAG_W + SCALE_W;
    localparam int NUM_W   = MAG_W + SCALE_SHIFT;
    localparam int FFV_W   = GAIN_W + 1 + VEL_W;
    localparam int KPE_W   = GAIN_W + 1 + ERR_W;
    localparam int SUM_W   = NUM_W + 3;
    localparam int RND_W   = SUM_W - FRAC_BITS + 1;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << FRAC_BITS;

    // axis order inside a transfer
    localparam int AX_X   = 0;
    localparam int AX_Y   = 1;
    localparam int AX_Z   = 2;
    localparam int AX_YAW = 3;

    localparam int MIN_INTERVAL_US_DEF = 10;

    // configuration register map
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_VEL  = 3'd0,
        REG_FF_X     = 3'd1,
        REG_FF_Y     = 3'd2,
        REG_FF_Z     = 3'd3,
        REG_FF_YAW   = 3'd4,
        REG_KP_XY    = 3'd5,
        REG_KD_LIN   = 3'd6,
        REG_KD_YAW   = 3'd7
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0] MAX_VEL_RST = 15'd4096;
    localparam logic [GAIN_W-1:0] FF_X_RST    = 15'd235;
    localparam logic [GAIN_W-1:0] FF_Y_RST    = 15'd298;
    localparam logic [GAIN_W-1:0] FF_Z_RST    = 15'd4016;
    localparam logic [GAIN_W-1:0] FF_YAW_RST  = 15'd2381;
    localparam logic [GAIN_W-1:0] KP_XY_RST   = 15'd7168;
    localparam logic [GAIN_W-1:0] KD_LIN_RST  = 15'd41;
    localparam logic [GAIN_W-1:0] KD_YAW_RST  = 15'd20;

    typedef struct packed {
        logic load_meas;
        logic load_cmd;
        logic go;
    } lane_ctl_t;

    typedef struct packed {
        logic [GAIN_W-1:0] ff;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] lim;
    } lane_gain_t;

    typedef struct packed {
        logic load;
        logic refreshed;
    } merge_ctl_t;

    typedef logic [NUM_AXES-1:0][VEL_W-1:0] drive_vec_t;

endpackage

`default_nettype wire

FILE: design/fpdvc_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module fpdvc_div #(
    parameter int DIVIDEND_W = fpdvc_pkg::NUM_W,
    parameter int DIVISOR_W  = fpdvc_pkg::TIME_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : DIVISOR_W'(trial);
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/fpdvc_lane.sv
`default_nettype none

// one axis of the controller: error, ff + p + d terms, rounding, clamp
module fpdvc_lane (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire fpdvc_pkg::lane_ctl_t               ctl,
    input  wire fpdvc_pkg::lane_gain_t              gain,
    input  wire logic signed [fpdvc_pkg::VEL_W-1:0] vel,
    input  wire logic [fpdvc_pkg::TIME_W-1:0]       dt_mag,
    input  wire logic                               dt_neg,
    output logic                                    done,
    output logic signed [fpdvc_pkg::VEL_W-1:0]      drive
);

    typedef enum logic [7:0] {
        L_IDLE  = 8'b0000_0001,
        L_PROD  = 8'b0000_0010,
        L_SCALE = 8'b0000_0100,
        L_LOAD  = 8'b0000_1000,
        L_DIV   = 8'b0001_0000,
        L_SUM   = 8'b0010_0000,
        L_RND   = 8'b0100_0000,
        L_SAT   = 8'b1000_0000
    } lane_state_t;

    lane_state_t state_reg, state_next;
    logic        done_reg;

    logic signed [fpdvc_pkg::VEL_W-1:0]   meas_reg;
    logic signed [fpdvc_pkg::ERR_W-1:0]   perr_reg;
    logic signed [fpdvc_pkg::VEL_W-1:0]   vel_reg;
    logic signed [fpdvc_pkg::ERR_W-1:0]   err_reg;
    logic signed [fpdvc_pkg::DE_W-1:0]    de_reg;
    logic signed [fpdvc_pkg::PD_W-1:0]    pd_reg;
    logic signed [fpdvc_pkg::FFV_W-1:0]   ffv_reg;
    logic signed [fpdvc_pkg::KPE_W-1:0]   kpe_reg;
    logic [fpdvc_pkg::MAG_W-1:0]          mag_reg;
    logic                                 pd_neg_reg;
    logic signed [fpdvc_pkg::SUM_W-1:0]   sum_reg;
    logic signed [fpdvc_pkg::RND_W-1:0]   rnd_reg;
    logic signed [fpdvc_pkg::VEL_W-1:0]   drive_reg;

    logic signed [fpdvc_pkg::ERR_W-1:0]   err;
    logic signed [fpdvc_pkg::DE_W-1:0]    de;
    logic [fpdvc_pkg::PDMAG_W-1:0]        pd_mag;
    logic [fpdvc_pkg::NUM_W-1:0]          dividend;
    logic [fpdvc_pkg::NUM_W-1:0]          quo;
    logic                                 div_done;
    logic signed [fpdvc_pkg::SUM_W-1:0]   q_s;
    logic signed [fpdvc_pkg::SUM_W-1:0]   dterm;
    logic [fpdvc_pkg::SUM_W-1:0]          s_mag;
    logic [fpdvc_pkg::SUM_W-1:0]          s_rnd;
    logic signed [fpdvc_pkg::RND_W-1:0]   r_pos;
    logic signed [fpdvc_pkg::RND_W-1:0]   lim;

    always_comb
    begin
        err = $signed({vel[fpdvc_pkg::VEL_W-1], vel})
            - $signed({meas_reg[fpdvc_pkg::VEL_W-1], meas_reg});
        de  = $signed({err[fpdvc_pkg::ERR_W-1], err})
            - $signed({perr_reg[fpdvc_pkg::ERR_W-1], perr_reg});
        pd_mag = pd_reg[fpdvc_pkg::PD_W-1] ? fpdvc_pkg::PDMAG_W'(-pd_reg)
                                            : fpdvc_pkg::PDMAG_W'(pd_reg);
        // magnitude of kd * de * 1e6 plus half the interval for rounding
        dividend = {mag_reg, fpdvc_pkg::SCALE_SHIFT'(0)}
                 + fpdvc_pkg::NUM_W'(dt_mag >> 1);
        q_s   = $signed({(fpdvc_pkg::SUM_W - fpdvc_pkg::NUM_W)'(0), quo});
        dterm = (pd_neg_reg ^ dt_neg) ? -q_s : q_s;
        s_mag = sum_reg[fpdvc_pkg::SUM_W-1] ? fpdvc_pkg::SUM_W'(-sum_reg)
                                             : fpdvc_pkg::SUM_W'(sum_reg);
        s_rnd = (s_mag + fpdvc_pkg::ROUND_HALF) >> fpdvc_pkg::FRAC_BITS;
        r_pos = $signed(fpdvc_pkg::RND_W'(s_rnd));
        lim   = $signed({(fpdvc_pkg::RND_W - fpdvc_pkg::GAIN_W)'(0), gain.lim});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:  if (ctl.load_cmd && ctl.go) state_next = L_PROD;
            L_PROD:  state_next = L_SCALE;
            L_SCALE: state_next = L_LOAD;
            L_LOAD:  state_next = L_DIV;
            L_DIV:   if (div_done) state_next = L_SUM;
            L_SUM:   state_next = L_RND;
            L_RND:   state_next = L_SAT;
            L_SAT:   state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            meas_reg  <= '0;
            perr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == L_SAT);
            if (ctl.load_meas)
            begin
                meas_reg <= vel;
            end
            if (ctl.load_cmd)
            begin
                perr_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_cmd)
        begin
            vel_reg <= vel;
            err_reg <= err;
            de_reg  <= de;
        end
        if (state_reg == L_PROD)
        begin
            pd_reg  <= $signed({1'b0, gain.kd}) * de_reg;
            ffv_reg <= $signed({1'b0, gain.ff}) * vel_reg;
        end
        if (state_reg == L_SCALE)
        begin
            mag_reg    <= pd_mag * fpdvc_pkg::D_SCALE;
            pd_neg_reg <= pd_reg[fpdvc_pkg::PD_W-1];
            kpe_reg    <= $signed({1'b0, gain.kp}) * err_reg;
        end
        if (state_reg == L_SUM)
        begin
            sum_reg <= fpdvc_pkg::SUM_W'(ffv_reg) + fpdvc_pkg::SUM_W'(kpe_reg) + dterm;
        end
        if (state_reg == L_RND)
        begin
            rnd_reg <= sum_reg[fpdvc_pkg::SUM_W-1] ? -r_pos : r_pos;
        end
        if (state_reg == L_SAT)
        begin
            if (rnd_reg > lim)
            begin
                drive_reg <= fpdvc_pkg::VEL_W'(lim);
            end
            else if (rnd_reg < -lim)
            begin
                drive_reg <= fpdvc_pkg::VEL_W'(-lim);
            end
            else
            begin
                drive_reg <= fpdvc_pkg::VEL_W'(rnd_reg);
            end
        end
    end

    fpdvc_div #(
        .DIVIDEND_W (fpdvc_pkg::NUM_W),
        .DIVISOR_W  (fpdvc_pkg::TIME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == L_LOAD),
        .dividend (dividend),
        .divisor  (dt_mag),
        .done     (div_done),
        .quotient (quo)
    );

    assign done  = done_reg;
    assign drive = drive_reg;

endmodule

`default_nettype wire

FILE: design/fpdvc_merge.sv
`default_nettype none

// gathers the lane drives, keeps the held drive, owns the output register
module fpdvc_merge (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire fpdvc_pkg::merge_ctl_t  ctl,
    input  wire fpdvc_pkg::drive_vec_t  lane_drive,
    output logic                        free,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [fpdvc_pkg::NUM_AXES*fpdvc_pkg::VEL_W-1:0] m_tdata,
    output logic                        m_tuser
);

    fpdvc_pkg::drive_vec_t held_reg, held_next;
    logic                  valid_reg;
    logic [fpdvc_pkg::NUM_AXES*fpdvc_pkg::VEL_W-1:0] data_reg;
    logic                  user_reg;

    always_comb
    begin
        held_next = held_reg;
        if (ctl.refreshed)
        begin
            held_next = lane_drive;
            // yaw goes out with the opposite sign
            held_next[fpdvc_pkg::AX_YAW] = -lane_drive[fpdvc_pkg::AX_YAW];
        end
    end

    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            held_reg  <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                valid_reg <= 1'b1;
                held_reg  <= held_next;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            data_reg <= held_next;
            user_reg <= ctl.refreshed;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire

FILE: design/feedforward_pd_velocity_control_core.sv
// measurement transfer: taken while idle, gives no result, next transfer the cycle after
// command, short interval: held drive goes from the emit state into the output register once the slot is free
// command, long interval: each axis lane computes a new drive, its derivative term coming from
// the 53-step bit-serial divider in that lane, and the drives then go to the output register
// one item in flight at a time; a finished result may wait in the output register
// rst_n (async, active low) restores register defaults and zeroes the stored measurement and error of each axis
`default_nettype none

module feedforward_pd_velocity_control_core #(
    parameter int MIN_INTERVAL_US = fpdvc_pkg::MIN_INTERVAL_US_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // vel_x, vel_y, vel_z, yaw_rate, stamp_us
    input  wire logic        s_tuser,   // cmd
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // drive_x, drive_y, drive_z, drive_yaw
    output logic             m_tuser,   // refreshed
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [fpdvc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fpdvc_pkg::GAIN_W-1:0]    cfg_data
);

    // top-level sequencer: idle, lanes running, result waiting for the output slot
    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_BUSY = 3'b010,
        T_EMIT = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;
    logic       refresh_reg;

    // configuration registers
    logic [fpdvc_pkg::GAIN_W-1:0] max_vel_reg;
    logic [fpdvc_pkg::GAIN_W-1:0] ff_x_reg;
    logic [fpdvc_pkg::GAIN_W-1:0] ff_y_reg;
    logic [fpdvc_pkg::GAIN_W-1:0] ff_z_reg;
    logic [fpdvc_pkg::GAIN_W-1:0] ff_yaw_reg;
    logic [fpdvc_pkg::GAIN_W-1:0] kp_xy_reg;
    logic [fpdvc_pkg::GAIN_W-1:0] kd_lin_reg;
    logic [fpdvc_pkg::GAIN_W-1:0] kd_yaw_reg;

    // timing state
    logic [fpdvc_pkg::TIME_W-1:0] sample_time_reg;
    logic [fpdvc_pkg::TIME_W-1:0] prev_time_reg;
    logic [fpdvc_pkg::TIME_W-1:0] dt_mag_reg;
    logic                         dt_neg_reg;

    logic                         in_xfer;
    logic                         is_cmd;
    logic [fpdvc_pkg::TIME_W-1:0] stamp;
    logic [fpdvc_pkg::TIME_W-1:0] du;
    logic [fpdvc_pkg::TIME_W-1:0] adt;
    logic                         refresh;

    fpdvc_pkg::lane_ctl_t  lane_ctl;
    fpdvc_pkg::lane_gain_t lane_gain [fpdvc_pkg::NUM_AXES];
    fpdvc_pkg::drive_vec_t lane_drive;
    logic [fpdvc_pkg::NUM_AXES-1:0] lane_done;
    fpdvc_pkg::merge_ctl_t merge_ctl;
    logic                  out_free;

    assign s_tready  = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign is_cmd    = s_tuser;
    assign stamp     = s_tdata[95:64];

    // signed interval since the previous command, as sign and magnitude
    always_comb
    begin
        du      = sample_time_reg - prev_time_reg;
        adt     = du[fpdvc_pkg::TIME_W-1] ? -du : du;
        refresh = adt > fpdvc_pkg::TIME_W'(MIN_INTERVAL_US);
    end

    // per-lane gain selection; z and yaw take unity proportional gain
    always_comb
    begin
        lane_gain[fpdvc_pkg::AX_X]   = '{ff: ff_x_reg, kp: kp_xy_reg,
                                         kd: kd_lin_reg, lim: max_vel_reg};
        lane_gain[fpdvc_pkg::AX_Y]   = '{ff: ff_y_reg, kp: kp_xy_reg,
                                         kd: kd_lin_reg, lim: max_vel_reg};
        lane_gain[fpdvc_pkg::AX_Z]   = '{ff: ff_z_reg, kp: fpdvc_pkg::UNITY_GAIN,
                                         kd: kd_lin_reg, lim: max_vel_reg};
        lane_gain[fpdvc_pkg::AX_YAW] = '{ff: ff_yaw_reg, kp: fpdvc_pkg::UNITY_GAIN,
                                         kd: kd_yaw_reg, lim: max_vel_reg};
    end

    always_comb
    begin
        lane_ctl.load_meas = in_xfer && !is_cmd;
        lane_ctl.load_cmd  = in_xfer && is_cmd;
        lane_ctl.go        = refresh;
        merge_ctl.load      = (state_reg == T_EMIT) && out_free;
        merge_ctl.refreshed = refresh_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_xfer && is_cmd)
                begin
                    state_next = refresh ? T_BUSY : T_EMIT;
                end
            end
            T_BUSY:  if (&lane_done) state_next = T_EMIT;
            T_EMIT:  if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            refresh_reg     <= 1'b0;
            sample_time_reg <= '0;
            prev_time_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer && !is_cmd)
            begin
                sample_time_reg <= stamp;
            end
            if (in_xfer && is_cmd)
            begin
                refresh_reg   <= refresh;
                prev_time_reg <= sample_time_reg;
            end
        end
    end

    // interval handed to the lane dividers, stable until the next command
    always_ff @(posedge clk)
    begin
        if (in_xfer && is_cmd)
        begin
            dt_mag_reg <= adt;
            dt_neg_reg <= du[fpdvc_pkg::TIME_W-1];
        end
    end

    // register writes, one transfer per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vel_reg <= fpdvc_pkg::MAX_VEL_RST;
            ff_x_reg    <= fpdvc_pkg::FF_X_RST;
            ff_y_reg    <= fpdvc_pkg::FF_Y_RST;
            ff_z_reg    <= fpdvc_pkg::FF_Z_RST;
            ff_yaw_reg  <= fpdvc_pkg::FF_YAW_RST;
            kp_xy_reg   <= fpdvc_pkg::KP_XY_RST;
            kd_lin_reg  <= fpdvc_pkg::KD_LIN_RST;
            kd_yaw_reg  <= fpdvc_pkg::KD_YAW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (fpdvc_pkg::cfg_reg_t'(cfg_index))
                fpdvc_pkg::REG_MAX_VEL: max_vel_reg <= cfg_data;
                fpdvc_pkg::REG_FF_X:    ff_x_reg    <= cfg_data;
                fpdvc_pkg::REG_FF_Y:    ff_y_reg    <= cfg_data;
                fpdvc_pkg::REG_FF_Z:    ff_z_reg    <= cfg_data;
                fpdvc_pkg::REG_FF_YAW:  ff_yaw_reg  <= cfg_data;
                fpdvc_pkg::REG_KP_XY:   kp_xy_reg   <= cfg_data;
                fpdvc_pkg::REG_KD_LIN:  kd_lin_reg  <= cfg_data;
                fpdvc_pkg::REG_KD_YAW:  kd_yaw_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // one lane per axis, all running in lockstep
    for (genvar i = 0; i < fpdvc_pkg::NUM_AXES; i++)
    begin : g_lane
        fpdvc_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lane_ctl),
            .gain   (lane_gain[i]),
            .vel    (s_tdata[i*fpdvc_pkg::VEL_W +: fpdvc_pkg::VEL_W]),
            .dt_mag (dt_mag_reg),
            .dt_neg (dt_neg_reg),
            .done   (lane_done[i]),
            .drive  (lane_drive[i])
        );
    end

    // merging stage: yaw sign flip, held drive, output register
    fpdvc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (merge_ctl),
        .lane_drive (lane_drive),
        .free       (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
